// File: rtl/core/vpd_pkg.sv
package vpd_pkg;

   localparam int LETTER_W            = 5;
   localparam int ALPHABET            = 26;
   localparam int SIDE                = 5;
   localparam int SIDE_W              = 3;
   localparam int LEN_W               = 4;
   localparam int CSR_W               = 60;
   localparam int CSR_IDX_W           = 3;
   localparam int ROW_PAIR_W          = 2 * SIDE * LETTER_W;
   localparam int ROW_W               = SIDE * LETTER_W;
   localparam int DEF_MAX_KEY_LETTERS = 12;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VIGENERE_KEY    = 3'd0,
      CSR_VIGENERE_LENGTH = 3'd1,
      CSR_SQUARE_ROWS_0_1 = 3'd2,
      CSR_SQUARE_ROWS_2_3 = 3'd3,
      CSR_SQUARE_ROW_4    = 3'd4
   } csr_index_type;

   typedef logic [LETTER_W-1:0] letter_type;
   typedef logic [SIDE_W-1:0]   coord_type;

endpackage

// File: rtl/core/vpd_req_if.sv
interface vpd_req_if
   import vpd_pkg::*;
();
   logic       valid;
   logic       ready;
   letter_type cipher_letter;
   logic       last;

   modport source (output valid, output cipher_letter, output last, input ready);
   modport sink   (input valid, input cipher_letter, input last, output ready);
endinterface

// File: rtl/core/vpd_rsp_if.sv
interface vpd_rsp_if
   import vpd_pkg::*;
();
   logic       valid;
   logic       ready;
   letter_type plain_first;
   letter_type plain_second;
   logic       last_res;

   modport source (output valid, output plain_first, output plain_second,
                   output last_res, input ready);
   modport sink   (input valid, input plain_first, input plain_second,
                   input last_res, output ready);
endinterface

// File: rtl/core/vigenere_playfair_decrypt_unit.sv
// Vigenere + Playfair decrypt unit. Takes one ciphertext letter per beat on
// req_if and returns one decrypted letter pair per two letters on rsp_if. The
// block sustains one letter per cycle while pairs are taken: the repeating key
// is removed as a letter is taken into the input register, and the square
// lookup and pair rule run between that register and the result register, so
// a pair is offered on rsp_if once its second letter reaches the result register.
// A pair that waits to be taken holds the input register, so at most one more
// letter is accepted until the pair leaves; that letter, even one that opens a
// pair, waits behind it. A message ends
// on a letter with last set; that clears the key position and any held letter,
// and an unpaired final letter is dropped. Program the key, key length and the
// 5x5 square through the csr_ port only while no letter is in flight. A letter
// missing from the square (such as J) is treated as row 0, column 0.
module vigenere_playfair_decrypt_unit
   import vpd_pkg::*;
#(
   parameter int MAX_KEY_LETTERS = DEF_MAX_KEY_LETTERS
) (
   input  logic                 clock,
   input  logic                 reset,
   vpd_req_if.sink              req_if,
   vpd_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   localparam int KEY_W = MAX_KEY_LETTERS * LETTER_W;

   // configuration registers
   logic [KEY_W-1:0]      key_ff, key_in;
   logic [LEN_W-1:0]      len_ff, len_in;
   logic [ROW_PAIR_W-1:0] rows01_ff, rows01_in;
   logic [ROW_PAIR_W-1:0] rows23_ff, rows23_in;
   logic [ROW_W-1:0]      row4_ff, row4_in;

   // key walk
   logic [LEN_W-1:0] kpos_ff, kpos_in;

   // input register: letter with key already removed
   logic       s1_valid_ff, s1_valid_in;
   letter_type s1_letter_ff, s1_letter_in;
   logic       s1_last_ff, s1_last_in;

   // held first letter of a pair, kept as its square position
   logic      held_ff, held_in;
   coord_type held_row_ff, held_row_in;
   coord_type held_col_ff, held_col_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   letter_type rsp_first_ff, rsp_first_in;
   letter_type rsp_second_ff, rsp_second_in;
   logic       rsp_last_ff, rsp_last_in;

   logic accept;
   logic out_free;
   logic s1_go;

   logic [LEN_W-1:0] len_use;
   logic [LEN_W-1:0] pos_use;
   letter_type       key_letter;
   logic [6:0]       diff;
   letter_type       plain_v;

   letter_type sq [SIDE][SIDE];
   coord_type  cur_row, cur_col;
   coord_type  sel_r0, sel_c0, sel_r1, sel_c1;
   letter_type pick0, pick1;

   function automatic coord_type step_back(coord_type x);
      coord_type r;
      if (x == '0) begin
         r = SIDE_W'(SIDE - 1);
      end else begin
         r = x - 1'b1;
      end
      return r;
   endfunction

   // handshake: input register may fill whenever it is empty or draining
   assign out_free       = !rsp_valid_ff || rsp_if.ready;
   assign s1_go          = s1_valid_ff && out_free;
   assign req_if.ready   = !s1_valid_ff || out_free;
   assign accept         = req_if.valid && req_if.ready;

   assign rsp_if.valid        = rsp_valid_ff;
   assign rsp_if.plain_first  = rsp_first_ff;
   assign rsp_if.plain_second = rsp_second_ff;
   assign rsp_if.last_res     = rsp_last_ff;

   // configuration writes
   always_comb begin
      key_in    = key_ff;
      len_in    = len_ff;
      rows01_in = rows01_ff;
      rows23_in = rows23_ff;
      row4_in   = row4_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_VIGENERE_KEY:    key_in    = csr_wdata[KEY_W-1:0];
            CSR_VIGENERE_LENGTH: len_in    = csr_wdata[LEN_W-1:0];
            CSR_SQUARE_ROWS_0_1: rows01_in = csr_wdata[ROW_PAIR_W-1:0];
            CSR_SQUARE_ROWS_2_3: rows23_in = csr_wdata[ROW_PAIR_W-1:0];
            CSR_SQUARE_ROW_4:    row4_in   = csr_wdata[ROW_W-1:0];
            default:             ;
         endcase
      end
   end

   // key removal on the incoming beat
   always_comb begin
      priority if (len_ff == '0) begin
         len_use = LEN_W'(1);
      end else if (len_ff > LEN_W'(MAX_KEY_LETTERS)) begin
         len_use = LEN_W'(MAX_KEY_LETTERS);
      end else begin
         len_use = len_ff;
      end
      // a position left over from a longer key wraps to the start
      pos_use = (kpos_ff >= len_use) ? '0 : kpos_ff;

      key_letter = '0;
      for (int i = 0; i < MAX_KEY_LETTERS; i++) begin
         if (pos_use == LEN_W'(i)) begin
            key_letter = key_ff[i*LETTER_W +: LETTER_W];
         end
      end

      // c + 2*26 - k stays within 21..83, so three folds suffice
      diff = 7'(req_if.cipher_letter) + 7'(2 * ALPHABET) - 7'(key_letter);
      priority if (diff >= 7'(3 * ALPHABET)) begin
         plain_v = LETTER_W'(diff - 7'(3 * ALPHABET));
      end else if (diff >= 7'(2 * ALPHABET)) begin
         plain_v = LETTER_W'(diff - 7'(2 * ALPHABET));
      end else if (diff >= 7'(ALPHABET)) begin
         plain_v = LETTER_W'(diff - 7'(ALPHABET));
      end else begin
         plain_v = LETTER_W'(diff);
      end

      kpos_in      = kpos_ff;
      s1_letter_in = s1_letter_ff;
      s1_last_in   = s1_last_ff;
      if (accept) begin
         s1_letter_in = plain_v;
         s1_last_in   = req_if.last;
         if (req_if.last || (pos_use + 1'b1 == len_use)) begin
            kpos_in = '0;
         end else begin
            kpos_in = pos_use + 1'b1;
         end
      end

      priority if (accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_go) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // square cells at fixed places
   always_comb begin
      for (int c = 0; c < SIDE; c++) begin
         sq[0][c] = rows01_ff[c*LETTER_W +: LETTER_W];
         sq[1][c] = rows01_ff[(SIDE + c)*LETTER_W +: LETTER_W];
         sq[2][c] = rows23_ff[c*LETTER_W +: LETTER_W];
         sq[3][c] = rows23_ff[(SIDE + c)*LETTER_W +: LETTER_W];
         sq[4][c] = row4_ff[c*LETTER_W +: LETTER_W];
      end
   end

   // locate the registered letter; first match in row-major order wins
   always_comb begin
      cur_row = '0;
      cur_col = '0;
      for (int r = SIDE - 1; r >= 0; r--) begin
         for (int c = SIDE - 1; c >= 0; c--) begin
            if (sq[r][c] == s1_letter_ff) begin
               cur_row = SIDE_W'(r);
               cur_col = SIDE_W'(c);
            end
         end
      end
   end

   // pair rule: column test first, then row, then swap columns
   always_comb begin
      priority if (held_col_ff == cur_col) begin
         sel_r0 = step_back(held_row_ff);
         sel_c0 = held_col_ff;
         sel_r1 = step_back(cur_row);
         sel_c1 = cur_col;
      end else if (held_row_ff == cur_row) begin
         sel_r0 = held_row_ff;
         sel_c0 = step_back(held_col_ff);
         sel_r1 = cur_row;
         sel_c1 = step_back(cur_col);
      end else begin
         sel_r0 = held_row_ff;
         sel_c0 = cur_col;
         sel_r1 = cur_row;
         sel_c1 = held_col_ff;
      end

      pick0 = '0;
      pick1 = '0;
      for (int r = 0; r < SIDE; r++) begin
         for (int c = 0; c < SIDE; c++) begin
            if (sel_r0 == SIDE_W'(r) && sel_c0 == SIDE_W'(c)) begin
               pick0 = sq[r][c];
            end
            if (sel_r1 == SIDE_W'(r) && sel_c1 == SIDE_W'(c)) begin
               pick1 = sq[r][c];
            end
         end
      end
   end

   // advance the pair state and load the result register
   always_comb begin
      held_in       = held_ff;
      held_row_in   = held_row_ff;
      held_col_in   = held_col_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_second_in = rsp_second_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_if.ready;

      if (s1_go) begin
         if (held_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_first_in  = pick0;
            rsp_second_in = pick1;
            rsp_last_in   = s1_last_ff;
            held_in       = 1'b0;
         end else begin
            // hold the opener; drop it when it ends the message
            held_in     = !s1_last_ff;
            held_row_in = cur_row;
            held_col_in = cur_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff       <= '0;
         len_ff       <= LEN_W'(1);
         rows01_ff    <= '0;
         rows23_ff    <= '0;
         row4_ff      <= '0;
         kpos_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         held_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_ff       <= key_in;
         len_ff       <= len_in;
         rows01_ff    <= rows01_in;
         rows23_ff    <= rows23_in;
         row4_ff      <= row4_in;
         kpos_ff      <= kpos_in;
         s1_valid_ff  <= s1_valid_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_letter_ff  <= s1_letter_in;
      s1_last_ff    <= s1_last_in;
      held_row_ff   <= held_row_in;
      held_col_ff   <= held_col_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_second_ff <= rsp_second_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule
